@@ hdl/idfs_pkg.sv @@
// Shared types, codes and text tables for the IPP document-format scanner.
`default_nettype none

package idfs_pkg;

  // Width of the running byte index inside a message
  localparam int OFFSET_BITS = 24;
  localparam int DOC_OFFSET_W = 24;

  // Header length and tag codes
  localparam int HEADER_BYTES = 8;
  localparam logic [7:0] TAG_END = 8'h03;
  localparam logic [7:0] TAG_DELIM_MIN = 8'h01;
  localparam logic [7:0] TAG_DELIM_MAX = 8'h05;
  localparam logic [7:0] TAG_MIME = 8'h49;

  // Result kinds
  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_PWG = 2'd1;
  localparam logic [1:0] KIND_UNSUP = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Texts compared byte by byte
  localparam int NAME_LEN = 15;
  localparam int RAW_LEN = 24;
  localparam int PWG_LEN = 16;
  localparam logic [8*NAME_LEN-1:0] NAME_TEXT = "document-format";
  localparam logic [8*RAW_LEN-1:0] RAW_TEXT = "application/octet-stream";
  localparam logic [8*PWG_LEN-1:0] PWG_TEXT = "image/pwg-raster";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]              format_kind;
    logic [DOC_OFFSET_W-1:0] doc_offset;
  } out_t;

  // Character idx of "document-format"
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(idx) < NAME_LEN) begin
      ch = NAME_TEXT[8*(NAME_LEN-1-int'(idx)) +: 8];
    end
    return ch;
  endfunction

  // Character idx of "application/octet-stream"
  function automatic logic [7:0] raw_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(idx) < RAW_LEN) begin
      ch = RAW_TEXT[8*(RAW_LEN-1-int'(idx)) +: 8];
    end
    return ch;
  endfunction

  // Character idx of "image/pwg-raster"
  function automatic logic [7:0] pwg_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(idx) < PWG_LEN) begin
      ch = PWG_TEXT[8*(PWG_LEN-1-int'(idx)) +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ hdl/idfs_parser.sv @@
// Attribute record walker: per-byte state update and decision logic.
`default_nettype none

module idfs_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire idfs_pkg::in_t in_req,
  output logic               emit,
  output idfs_pkg::out_t     result
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_NLEN_HI = 3'd2;
  localparam logic [2:0] PH_NLEN_LO = 3'd3;
  localparam logic [2:0] PH_NAME    = 3'd4;
  localparam logic [2:0] PH_VLEN_HI = 3'd5;
  localparam logic [2:0] PH_VLEN_LO = 3'd6;
  localparam logic [2:0] PH_VALUE   = 3'd7;

  localparam int PW = idfs_pkg::OFFSET_BITS;
  localparam int DW = idfs_pkg::DOC_OFFSET_W;
  localparam logic [PW-1:0] POS_LIMIT = '1;
  localparam logic [PW-1:0] HEADER_LAST = PW'(idfs_pkg::HEADER_BYTES - 1);

  logic [2:0]    phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [7:0]    len_hi_r, len_hi_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic          name_match_r, name_match_nxt;
  logic          raw_match_r, raw_match_nxt;
  logic          pwg_match_r, pwg_match_nxt;
  logic          fmt_seen_r, fmt_seen_nxt;
  logic          kind_r, kind_nxt;
  logic          decided_r, decided_nxt;

  logic [7:0]       b;
  logic [15:0]      len;
  logic [15:0]      rem_dec;
  logic [15:0]      name_diff, raw_diff, pwg_diff;
  logic [DW+PW-1:0] off_wide;

  assign b         = in_req.data_byte;
  assign len       = {len_hi_r, b};
  assign rem_dec   = rem_r - 16'd1;
  assign name_diff = 16'(idfs_pkg::NAME_LEN) - rem_r;
  assign raw_diff  = 16'(idfs_pkg::RAW_LEN) - rem_r;
  assign pwg_diff  = 16'(idfs_pkg::PWG_LEN) - rem_r;
  assign off_wide  = {{DW{1'b0}}, pos_r + PW'(1)};

  // Compute next state and the decision for the byte at hand
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    len_hi_nxt     = len_hi_r;
    tag_nxt        = tag_r;
    name_match_nxt = name_match_r;
    raw_match_nxt  = raw_match_r;
    pwg_match_nxt  = pwg_match_r;
    fmt_seen_nxt   = fmt_seen_r;
    kind_nxt       = kind_r;
    decided_nxt    = decided_r;
    emit           = 1'b0;
    result         = '0;

    if (!decided_r) begin
      if (pos_r == POS_LIMIT) begin
        decided_nxt        = 1'b1;
        emit               = 1'b1;
        result.format_kind = idfs_pkg::KIND_BAD;
      end else begin
        pos_nxt = pos_r + PW'(1);
        case (phase_r)
          PH_HEADER: begin
            if (pos_r >= HEADER_LAST) phase_nxt = PH_TAG;
          end
          PH_TAG: begin
            if (b == idfs_pkg::TAG_END) begin
              decided_nxt        = 1'b1;
              emit               = 1'b1;
              result.format_kind = {1'b0, kind_r};
              result.doc_offset  = off_wide[DW-1:0];
            end else if (b inside {[idfs_pkg::TAG_DELIM_MIN:idfs_pkg::TAG_DELIM_MAX]}) begin
              // delimiter tag: stay
            end else begin
              tag_nxt   = b;
              phase_nxt = PH_NLEN_HI;
            end
          end
          PH_NLEN_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_NLEN_LO;
          end
          PH_NLEN_LO: begin
            rem_nxt        = len;
            name_match_nxt = (len == 16'(idfs_pkg::NAME_LEN));
            phase_nxt      = (len != 16'd0) ? PH_NAME : PH_VLEN_HI;
          end
          PH_NAME: begin
            if (name_match_r && (rem_r == 16'd0 || rem_r > 16'(idfs_pkg::NAME_LEN) ||
                idfs_pkg::name_char(name_diff[3:0]) != b)) begin
              name_match_nxt = 1'b0;
            end
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) phase_nxt = PH_VLEN_HI;
          end
          PH_VLEN_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_VLEN_LO;
          end
          PH_VLEN_LO: begin
            rem_nxt = len;
            if (name_match_r) begin
              if (fmt_seen_r || tag_r != idfs_pkg::TAG_MIME || len == 16'd0) begin
                decided_nxt        = 1'b1;
                emit               = 1'b1;
                result.format_kind = idfs_pkg::KIND_UNSUP;
              end else begin
                fmt_seen_nxt  = 1'b1;
                raw_match_nxt = (len == 16'(idfs_pkg::RAW_LEN));
                pwg_match_nxt = (len == 16'(idfs_pkg::PWG_LEN));
                phase_nxt     = PH_VALUE;
              end
            end else begin
              raw_match_nxt = 1'b0;
              pwg_match_nxt = 1'b0;
              phase_nxt     = (len != 16'd0) ? PH_VALUE : PH_TAG;
            end
          end
          PH_VALUE: begin
            if (raw_match_r && (rem_r == 16'd0 || rem_r > 16'(idfs_pkg::RAW_LEN) ||
                idfs_pkg::raw_char(raw_diff[4:0]) != b)) begin
              raw_match_nxt = 1'b0;
            end
            if (pwg_match_r && (rem_r == 16'd0 || rem_r > 16'(idfs_pkg::PWG_LEN) ||
                idfs_pkg::pwg_char(pwg_diff[3:0]) != b)) begin
              pwg_match_nxt = 1'b0;
            end
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              if (name_match_r && !raw_match_nxt && !pwg_match_nxt) begin
                decided_nxt        = 1'b1;
                emit               = 1'b1;
                result.format_kind = idfs_pkg::KIND_UNSUP;
              end else begin
                if (name_match_r) kind_nxt = !raw_match_nxt;
                name_match_nxt = 1'b0;
                raw_match_nxt  = 1'b0;
                pwg_match_nxt  = 1'b0;
                phase_nxt      = PH_TAG;
              end
            end
          end
          default: begin
            phase_nxt = PH_TAG;
          end
        endcase
      end

      // Flag a message that ends undecided
      if (in_req.last_byte && !decided_nxt) begin
        decided_nxt        = 1'b1;
        emit               = 1'b1;
        result.format_kind = idfs_pkg::KIND_BAD;
        result.doc_offset  = '0;
      end
    end

    // Drop all state at the end of a request
    if (in_req.last_byte) begin
      phase_nxt      = PH_HEADER;
      pos_nxt        = '0;
      rem_nxt        = '0;
      len_hi_nxt     = '0;
      tag_nxt        = '0;
      name_match_nxt = 1'b0;
      raw_match_nxt  = 1'b0;
      pwg_match_nxt  = 1'b0;
      fmt_seen_nxt   = 1'b0;
      kind_nxt       = 1'b0;
      decided_nxt    = 1'b0;
    end
  end

  // Advance state once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      pos_r        <= '0;
      rem_r        <= '0;
      len_hi_r     <= '0;
      tag_r        <= '0;
      name_match_r <= 1'b0;
      raw_match_r  <= 1'b0;
      pwg_match_r  <= 1'b0;
      fmt_seen_r   <= 1'b0;
      kind_r       <= 1'b0;
      decided_r    <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      rem_r        <= rem_nxt;
      len_hi_r     <= len_hi_nxt;
      tag_r        <= tag_nxt;
      name_match_r <= name_match_nxt;
      raw_match_r  <= raw_match_nxt;
      pwg_match_r  <= pwg_match_nxt;
      fmt_seen_r   <= fmt_seen_nxt;
      kind_r       <= kind_nxt;
      decided_r    <= decided_nxt;
    end
  end

  // At most one result per request
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    decided_r |-> !emit)
    else $error("result produced after decision");

  // Last byte returns the walker to the header phase
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_req.last_byte |=> phase_r == PH_HEADER && pos_r == '0 && !decided_r)
    else $error("state not cleared after last byte");

  // Rejected requests carry no offset
  a_reject_offset: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (result.format_kind == idfs_pkg::KIND_UNSUP ||
             result.format_kind == idfs_pkg::KIND_BAD) |-> result.doc_offset == '0)
    else $error("nonzero offset on rejected request");

endmodule

`default_nettype wire

@@ hdl/ipp_document_format_scanner.sv @@
// Top level of the IPP document-format scanner: handshakes and result register.
//
// Input channel (in_valid / in_stall / in_data): one byte of an IPP request per
// transfer, with last_byte set on the final byte of the request.
// Output channel (out_valid / out_stall / out_data): at most one result per
// request, giving format_kind and doc_offset (offset of the first document
// byte, meaningful for raw and pwg kinds; zero otherwise).
// Throughput: one byte per cycle, except while a deciding byte waits for a
// stalled result register. Each byte is captured in an input register and its
// state update plus decision run combinationally from there.
// Path: the accepting edge loads the deciding byte into the input register;
// its result then passes into the result register and shows on out_valid.
// Stall: a waiting result holds in the result register. Bytes that decide
// nothing keep flowing; a deciding byte waits in the input register until the
// result register frees, which in turn stalls the input channel.
// Reset: rst_n low for one clock empties both registers and returns the
// walker to the start of a request header.
`default_nettype none

module ipp_document_format_scanner (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire idfs_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output idfs_pkg::out_t     out_data
);

  logic           in_reg_valid_r, in_reg_valid_nxt;
  idfs_pkg::in_t  in_reg_r;
  logic           out_valid_r, out_valid_nxt;
  idfs_pkg::out_t out_data_r;

  logic           emit;
  idfs_pkg::out_t result;
  logic           advance;
  logic           load;

  // Consume the held byte unless its result has nowhere to go
  assign advance  = in_reg_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = in_reg_valid_r && !advance;
  assign load     = in_valid && !in_stall;

  idfs_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .in_req (in_reg_r),
    .emit   (emit),
    .result (result)
  );

  // Input register control
  always_comb begin
    in_reg_valid_nxt = in_reg_valid_r;
    if (load) begin
      in_reg_valid_nxt = 1'b1;
    end else if (advance) begin
      in_reg_valid_nxt = 1'b0;
    end
  end

  // Result register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_reg_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      in_reg_valid_r <= in_reg_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (load) in_reg_r <= in_data;
    if (advance && emit) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A decision lands in the result register on the next cycle
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> out_valid_r && out_data_r == $past(result))
    else $error("decision not captured in result register");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && in_reg_valid_r && emit |-> in_stall)
    else $error("pending result would be overwritten");

  // An accepted request byte is held for the walker
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_reg_valid_r)
    else $error("accepted byte not held");

endmodule

`default_nettype wire

@@ test/idfs_result_checker.sv @@
// Result checker for the IPP document-format scanner: predicts and compares results.
`timescale 1ns / 1ps

module idfs_result_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_stall,
  input  wire idfs_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_stall,
  input  wire idfs_pkg::out_t out_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked
);

  typedef enum logic [3:0] {
    SCAN_HEADER,
    SCAN_TAG,
    SCAN_NLEN_HI,
    SCAN_NLEN_LO,
    SCAN_NAME,
    SCAN_VLEN_HI,
    SCAN_VLEN_LO,
    SCAN_VALUE
  } scan_phase_t;

  localparam int PW = idfs_pkg::OFFSET_BITS;
  localparam int DW = idfs_pkg::DOC_OFFSET_W;
  localparam logic [PW-1:0] POS_LIMIT = {PW{1'b1}};

  string name_ref = "document-format";
  string raw_ref  = "application/octet-stream";
  string pwg_ref  = "image/pwg-raster";

  // Predicted walker state
  scan_phase_t   phase;
  logic [PW-1:0] byte_pos;
  logic [15:0]   remaining;
  logic [7:0]    len_hi;
  logic [7:0]    rec_tag;
  logic          name_hit;
  logic          raw_hit;
  logic          pwg_hit;
  logic          format_seen;
  logic [1:0]    kind_so_far;
  logic          decided;

  idfs_pkg::out_t expected_formats[$];
  idfs_pkg::out_t want;

  // Return the walker to the start of a message
  function automatic void clear_scan();
    phase       = SCAN_HEADER;
    byte_pos    = '0;
    remaining   = '0;
    len_hi      = '0;
    rec_tag     = '0;
    name_hit    = 1'b0;
    raw_hit     = 1'b0;
    pwg_hit     = 1'b0;
    format_seen = 1'b0;
    kind_so_far = idfs_pkg::KIND_RAW;
    decided     = 1'b0;
  endfunction

  // Record the one result of the current message
  function automatic void settle(input logic [1:0] kind, input logic [DW-1:0] offset);
    idfs_pkg::out_t res;
    res.format_kind = kind;
    res.doc_offset  = offset;
    decided = 1'b1;
    expected_formats.push_back(res);
  endfunction

  // Advance the predicted walker by one accepted request
  function automatic void scan_byte(input idfs_pkg::in_t req);
    logic [7:0]  b;
    logic [15:0] len;
    b   = req.data_byte;
    len = {len_hi, b};
    if (!decided) begin
      if (byte_pos >= POS_LIMIT) begin
        settle(idfs_pkg::KIND_BAD, '0);
      end else begin
        case (phase)
          SCAN_HEADER: begin
            if (byte_pos >= idfs_pkg::HEADER_BYTES - 1) phase = SCAN_TAG;
          end
          SCAN_TAG: begin
            if (b == idfs_pkg::TAG_END) begin
              settle(kind_so_far, DW'(byte_pos + 1));
            end else if (b < idfs_pkg::TAG_DELIM_MIN || b > idfs_pkg::TAG_DELIM_MAX) begin
              rec_tag = b;
              phase   = SCAN_NLEN_HI;
            end
          end
          SCAN_NLEN_HI: begin
            len_hi = b;
            phase  = SCAN_NLEN_LO;
          end
          SCAN_NLEN_LO: begin
            remaining = len;
            name_hit  = (len == idfs_pkg::NAME_LEN);
            phase     = (len != 0) ? SCAN_NAME : SCAN_VLEN_HI;
          end
          SCAN_NAME: begin
            if (name_hit && (remaining == 0 || remaining > idfs_pkg::NAME_LEN ||
                             name_ref[idfs_pkg::NAME_LEN - remaining] != b))
              name_hit = 1'b0;
            remaining = remaining - 1'b1;
            if (remaining == 0) phase = SCAN_VLEN_HI;
          end
          SCAN_VLEN_HI: begin
            len_hi = b;
            phase  = SCAN_VLEN_LO;
          end
          SCAN_VLEN_LO: begin
            remaining = len;
            if (!name_hit) begin
              raw_hit = 1'b0;
              pwg_hit = 1'b0;
              phase   = (len != 0) ? SCAN_VALUE : SCAN_TAG;
            end else if (format_seen || rec_tag != idfs_pkg::TAG_MIME) begin
              // second format record or wrong value tag
              settle(idfs_pkg::KIND_UNSUP, '0);
            end else begin
              format_seen = 1'b1;
              raw_hit     = (len == idfs_pkg::RAW_LEN);
              pwg_hit     = (len == idfs_pkg::PWG_LEN);
              if (len == 0) settle(idfs_pkg::KIND_UNSUP, '0);
              else phase = SCAN_VALUE;
            end
          end
          SCAN_VALUE: begin
            if (raw_hit && (remaining == 0 || remaining > idfs_pkg::RAW_LEN ||
                            raw_ref[idfs_pkg::RAW_LEN - remaining] != b))
              raw_hit = 1'b0;
            if (pwg_hit && (remaining == 0 || remaining > idfs_pkg::PWG_LEN ||
                            pwg_ref[idfs_pkg::PWG_LEN - remaining] != b))
              pwg_hit = 1'b0;
            remaining = remaining - 1'b1;
            if (remaining == 0) begin
              if (name_hit && !raw_hit && !pwg_hit) begin
                settle(idfs_pkg::KIND_UNSUP, '0);
              end else begin
                if (name_hit) kind_so_far = raw_hit ? idfs_pkg::KIND_RAW : idfs_pkg::KIND_PWG;
                name_hit = 1'b0;
                raw_hit  = 1'b0;
                pwg_hit  = 1'b0;
                phase    = SCAN_TAG;
              end
            end
          end
          default: phase = SCAN_TAG;
        endcase
        byte_pos = byte_pos + 1'b1;
      end
    end
    // a message that ends undecided is malformed
    if (!decided && req.last_byte) settle(idfs_pkg::KIND_BAD, '0);
    if (req.last_byte) clear_scan();
  endfunction

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_formats.delete();
    end else begin
      if (in_valid && !in_stall) scan_byte(in_data);
      if (out_valid && !out_stall) begin
        if (expected_formats.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, got kind %0d offset %0d",
                   $time, out_data.format_kind, out_data.doc_offset);
        end else begin
          want = expected_formats.pop_front();
          results_checked++;
          if (out_data.format_kind !== want.format_kind) begin
            mismatches++;
            $display("%0t ns: format_kind expected %0d, got %0d",
                     $time, want.format_kind, out_data.format_kind);
          end
          if (out_data.doc_offset !== want.doc_offset) begin
            mismatches++;
            $display("%0t ns: doc_offset expected %0d, got %0d",
                     $time, want.doc_offset, out_data.doc_offset);
          end
        end
      end
    end
    outstanding = expected_formats.size();
  end

endmodule

@@ test/ipp_document_format_scanner_tb.sv @@
// Testbench top for the IPP document-format scanner: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module ipp_document_format_scanner_tb;

  localparam int RANDOM_BYTES     = 180;
  localparam int TIMEOUT_NS       = 3_000_000;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  idfs_pkg::in_t  in_data   = '0;
  logic           out_stall = 1'b0;
  logic           in_stall;
  logic           out_valid;
  idfs_pkg::out_t out_data;

  int mismatches;
  int outstanding;
  int results_checked;

  int send_idle_pct  = 10;
  int recv_stall_pct = 49;
  int bytes_sent     = 0;
  int messages_sent  = 0;

  logic [7:0] msg_bytes[$];

  always #4 clk = ~clk;

  // Stall the result channel at the current rate
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  ipp_document_format_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  idfs_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the built message, marking its final byte
  task automatic send_message();
    foreach (msg_bytes[i]) send_request(msg_bytes[i], i == msg_bytes.size() - 1);
    bytes_sent += msg_bytes.size();
    messages_sent++;
    msg_bytes.delete();
  endtask

  task automatic push_len(input int n);
    msg_bytes.push_back(n[15:8]);
    msg_bytes.push_back(n[7:0]);
  endtask

  task automatic push_random_bytes(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_text_field(input string s);
    push_len(s.len());
    foreach (s[i]) msg_bytes.push_back(s[i]);
  endtask

  task automatic push_random_field(input int n);
    push_len(n);
    push_random_bytes(n);
  endtask

  task automatic push_attr(input logic [7:0] tag, input string name, input string value);
    msg_bytes.push_back(tag);
    push_text_field(name);
    push_text_field(value);
  endtask

  task automatic trim_message(input int n);
    while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
  endtask

  // Any tag outside the delimiter range starts a record
  function automatic logic [7:0] record_tag();
    logic [7:0] tag;
    tag = 8'($urandom_range(255));
    if (tag >= idfs_pkg::TAG_DELIM_MIN && tag <= idfs_pkg::TAG_DELIM_MAX)
      tag = idfs_pkg::TAG_MIME;
    return tag;
  endfunction

  task automatic push_format_attr();
    msg_bytes.push_back(($urandom_range(99) < 90) ? idfs_pkg::TAG_MIME : record_tag());
    push_text_field("document-format");
    case ($urandom_range(9))
      0, 1, 2, 3: push_text_field("application/octet-stream");
      4, 5, 6:    push_text_field("image/pwg-raster");
      7:          push_text_field("image/pwg-rasteR");
      8:          push_text_field("application/pdf");
      default:    push_random_field($urandom_range(0, 30));
    endcase
  endtask

  task automatic push_other_attr();
    msg_bytes.push_back(record_tag());
    case ($urandom_range(3))
      0:       push_text_field("job-name");
      1:       push_text_field("document-formaT");
      default: push_random_field($urandom_range(0, 20));
    endcase
    if ($urandom_range(99) < 5) push_random_field($urandom_range(200, 300));
    else push_random_field($urandom_range(0, 20));
  endtask

  // Mostly well-formed messages, some truncated, some plain noise
  task automatic build_random_message();
    logic [7:0] delim;
    if ($urandom_range(99) < 12) begin
      push_random_bytes($urandom_range(1, 40));
    end else begin
      push_random_bytes(idfs_pkg::HEADER_BYTES);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(99) < 30) begin
          delim = 8'($urandom_range(1, 4));
          if (delim >= idfs_pkg::TAG_END) delim++;
          msg_bytes.push_back(delim);
        end
        if ($urandom_range(99) < 45) push_format_attr();
        else push_other_attr();
      end
      if ($urandom_range(99) < 90) msg_bytes.push_back(idfs_pkg::TAG_END);
      push_random_bytes($urandom_range(0, 4));
      if ($urandom_range(99) < 10) trim_message($urandom_range(1, msg_bytes.size()));
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    int random_start;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short messages ending inside the header
    msg_bytes.push_back(8'h00);
    send_message();
    repeat (5) msg_bytes.push_back(8'hFF);
    send_message();
    // Header alone, no end tag
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    send_message();
    // End tag on the final byte, then end tag followed by ignored bytes
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    msg_bytes.push_back(idfs_pkg::TAG_END);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Delimiters, then a raw format record
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    msg_bytes.push_back(8'h01);
    msg_bytes.push_back(8'h02);
    msg_bytes.push_back(8'h04);
    msg_bytes.push_back(8'h05);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "application/octet-stream");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Empty record with tag 0x00, ordinary records around a pwg format
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(8'h00, "", "");
    push_attr(8'hFF, "job-name", "x");
    push_attr(idfs_pkg::TAG_MIME, "document-format", "image/pwg-raster");
    push_attr(8'h21, "copies", "1");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Format record with the wrong tag
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(8'h44, "document-format", "image/pwg-raster");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Format named twice
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "image/pwg-raster");
    push_attr(idfs_pkg::TAG_MIME, "document-format", "application/octet-stream");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Unknown, empty and near-miss values
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "application/pdf");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "application/octet-streaM");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Near-miss name is just another record
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-formaT", "image/pwg-raster");
    msg_bytes.push_back(idfs_pkg::TAG_END);
    send_message();
    // Truncated inside name length, name, value length and value
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    msg_bytes.push_back(8'h44);
    msg_bytes.push_back(8'h00);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "image/pwg-raster");
    trim_message(idfs_pkg::HEADER_BYTES + 3 + 4);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "image/pwg-raster");
    trim_message(idfs_pkg::HEADER_BYTES + 3 + idfs_pkg::NAME_LEN + 1);
    send_message();
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "image/pwg-raster");
    trim_message(idfs_pkg::HEADER_BYTES + 3 + idfs_pkg::NAME_LEN + 2 + 5);
    send_message();
    // Largest name length, cut short
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    msg_bytes.push_back(8'h44);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'hFF);
    push_random_bytes(10);
    send_message();
    // Good format record but no end tag
    push_random_bytes(idfs_pkg::HEADER_BYTES);
    push_attr(idfs_pkg::TAG_MIME, "document-format", "application/octet-stream");
    send_message();

    drain_results();

    // Random traffic in three backpressure stages
    random_start = bytes_sent;
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (bytes_sent - random_start < RANDOM_BYTES * (stage + 1) / 3) begin
        build_random_message();
        send_message();
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    $display("Run covered %0d messages, %0d bytes: directed cases and random traffic",
             messages_sent, bytes_sent);
    $display("Compared %0d results under one-sided and no backpressure", results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ ipp_document_format_scanner.f @@
hdl/idfs_pkg.sv
hdl/idfs_parser.sv
hdl/ipp_document_format_scanner.sv
test/idfs_result_checker.sv
test/ipp_document_format_scanner_tb.sv
